// ===== sv/sbb_pkg.sv =====
// Shared constants, types and the 1-2-1 tap for the separable binomial blur.
package sbb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int CHANNELS   = 3;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int COORD_W  = 11;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int PAIR_W   = 2 * PIX_W;

    localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_FLD_W   = PIX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);
    localparam logic             BORDER_RST = 1'b1;
    localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BORDER = 2'd2
    } cfg_idx_t;

    // Item held in the sequencer: up to two column updates.
    typedef struct packed {
        logic               a_v;
        logic               b_v;
        logic [PIX_W-1:0]   ha;
        logic [PIX_W-1:0]   hb;
        logic [ADDR_W-1:0]  xa;
        logic [ADDR_W-1:0]  xb;
        logic [COORD_W-1:0] y;
        logic               yz;
        logic               e1;
        logic               e2;
        logic               fend;
    } seq_t;

    // One column update travelling to the line buffer and the output stage.
    typedef struct packed {
        logic               v;
        logic [PIX_W-1:0]   h;
        logic [ADDR_W-1:0]  xh;
        logic [COORD_W-1:0] y;
        logic               yz;
        logic               e1;
        logic               e2;
        logic               last;
        logic               fend;
    } op_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               run_end;
        logic               frame_end;
    } res_t;

    function automatic logic [CH_W-1:0] tap3(
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] c
    );
        logic [CH_W+1:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
        return s[CH_W+1:2];
    endfunction

endpackage

// ===== sv/sbb_line_buf.sv =====
// Line buffer RAM holding the older and newer horizontally blurred rows per column.
module sbb_line_buf
    import sbb_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PAIR_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PAIR_W-1:0] wr_data
);

    logic [PAIR_W-1:0] mem [MAX_WIDTH];
    logic [PAIR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sbb_lane.sv =====
// One colour channel lane: horizontal and vertical 1-2-1 taps.
module sbb_lane
    import sbb_pkg::*;
(
    input  logic [CH_W-1:0] left,
    input  logic [CH_W-1:0] centre,
    input  logic [CH_W-1:0] right,
    input  logic [CH_W-1:0] older,
    input  logic [CH_W-1:0] newer,
    input  logic [CH_W-1:0] h,
    output logic [CH_W-1:0] h_a,
    output logic [CH_W-1:0] h_b,
    output logic [CH_W-1:0] v_a,
    output logic [CH_W-1:0] v_b
);

    // h_b replicates the right edge pixel, v_b the bottom row
    assign h_a = tap3(left, centre, right);
    assign h_b = tap3(centre, right, right);
    assign v_a = tap3(older, newer, h);
    assign v_b = tap3(newer, h, h);

endmodule

// ===== sv/sbb_merge.sv =====
// Output stage: merges lane results into up to two result items and sends them one per transfer.
module sbb_merge
    import sbb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op,
    input  logic [PIX_W-1:0]       va,
    input  logic [PIX_W-1:0]       vb,
    output logic                   advance,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // red, green, blue, out_col, out_row, zero pad
    output logic                   m_tlast,
    output logic [0:0]             m_tuser   // frame_end
);

    logic p1_reg, p1_next;
    logic p2_reg, p2_next;
    res_t r1_reg, r1_next;
    res_t r2_reg, r2_next;
    res_t cur;
    logic m_fire;

    assign m_fire   = m_tvalid && m_tready;
    assign m_tvalid = p1_reg || p2_reg;
    assign advance  = (!p1_reg && !p2_reg) || (m_fire && !(p1_reg && p2_reg));

    always_comb
    begin
        p1_next = p1_reg;
        p2_next = p2_reg;
        r1_next = r1_reg;
        r2_next = r2_reg;
        if (advance)
        begin
            p1_next           = op.v && op.e1;
            p2_next           = op.v && op.e2;
            r1_next.pix       = va;
            r1_next.col       = COORD_W'(op.xh);
            r1_next.row       = op.y - COORD_W'(1);
            r1_next.run_end   = op.last && !op.e2;
            r1_next.frame_end = op.last && op.fend && !op.e2;
            r2_next.pix       = vb;
            r2_next.col       = COORD_W'(op.xh);
            r2_next.row       = op.y;
            r2_next.run_end   = op.last;
            r2_next.frame_end = op.last && op.fend;
        end
        else if (m_fire)
        begin
            // the row above leaves first
            if (p1_reg)
            begin
                p1_next = 1'b0;
            end
            else
            begin
                p2_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg <= r1_next;
        r2_reg <= r2_next;
    end

    assign cur     = p1_reg ? r1_reg : r2_reg;
    assign m_tdata = {(OUT_TDATA_W - OUT_FLD_W)'(0), cur.row, cur.col, cur.pix};
    assign m_tlast = cur.run_end;
    assign m_tuser = cur.frame_end;

endmodule

// ===== sv/separable_binomial_blur_3x3.sv =====
// Top level of the separable 3x3 binomial blur over a raster RGB pixel stream.
//
//  Group  Signals                         Moves
//  s_*    tvalid tready tdata[23:0]       one input pixel per transfer
//  m_*    tvalid tready tdata tlast tuser one blurred pixel per transfer
//  cfg_*  valid ready index data          one register write per transfer
//
// One pixel is taken per cycle unless s_tready is low. A row-end pixel in
// border mode makes two column updates on the single line buffer port and
// holds the input until the first one issues; results leave one per cycle
// while m_tready is high, so an item that yields several results stalls the
// input until they drain. Reset clears counters and pipeline valids; line
// buffer contents stay undefined and need no clearing pass.
module separable_binomial_blur_3x3
    import sbb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // red, green, blue, out_col, out_row, pad
    output logic                   m_tlast,   // run_end
    output logic [0:0]             m_tuser,   // frame_end
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               border_reg;
    logic [COORD_W-1:0] last_col;
    logic [COORD_W-1:0] last_row;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0]   prev_reg;
    logic [PIX_W-1:0]   prev2_reg;

    seq_t seq_reg, seq_next, seq_new;
    op_t  op_reg, iss;

    logic               in_fire;
    logic               advance;
    logic               xlast;
    logic               ylast;
    logic [PIX_W-1:0]   cur_pix;
    logic [PIX_W-1:0]   left_pix;
    logic [PIX_W-1:0]   ha_pix;
    logic [PIX_W-1:0]   hb_pix;
    logic [PIX_W-1:0]   va_pix;
    logic [PIX_W-1:0]   vb_pix;

    logic [PAIR_W-1:0]  mem_rd;
    logic [PAIR_W-1:0]  rd_pair;
    logic [PAIR_W-1:0]  wr_pair;
    logic               fwd_reg;
    logic [PAIR_W-1:0]  fwd_data_reg;
    logic [PIX_W-1:0]   older_pix;
    logic [PIX_W-1:0]   newer_pix;
    logic               wr_en;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            border_reg <= BORDER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_BORDER: border_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < SIZE_MIN)
            last_col = COORD_W'(2);
        else if (width_reg > CFG_W'(MAX_WIDTH))
            last_col = COORD_W'(MAX_WIDTH - 1);
        else
            last_col = COORD_W'(width_reg - CFG_W'(1));

        if (height_reg < SIZE_MIN)
            last_row = COORD_W'(2);
        else if (height_reg > CFG_W'(MAX_HEIGHT))
            last_row = COORD_W'(MAX_HEIGHT - 1);
        else
            last_row = COORD_W'(height_reg - CFG_W'(1));
    end

    // ------------------------------------------------------------ input side
    assign cur_pix  = s_tdata[PIX_W-1:0];
    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = !(seq_reg.a_v || seq_reg.b_v)
                      || (advance && !(seq_reg.a_v && seq_reg.b_v));
    assign xlast    = col_reg >= last_col;
    assign ylast    = row_reg >= last_row;
    assign left_pix = (border_reg && col_reg == COORD_W'(1)) ? prev_reg : prev2_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (xlast)
            begin
                col_next = '0;
                row_next = ylast ? '0 : row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_fire)
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= cur_pix;
            end
        end
    end

    always_comb
    begin
        seq_new.a_v  = border_reg ? (col_reg != '0) : (col_reg >= COORD_W'(2));
        seq_new.b_v  = border_reg && xlast;
        seq_new.ha   = ha_pix;
        seq_new.hb   = hb_pix;
        seq_new.xa   = ADDR_W'(col_reg - COORD_W'(1));
        seq_new.xb   = ADDR_W'(col_reg);
        seq_new.y    = row_reg;
        seq_new.yz   = row_reg == '0;
        seq_new.e1   = (row_reg != '0) && (border_reg || row_reg >= COORD_W'(2));
        seq_new.e2   = (row_reg != '0) && border_reg && ylast;
        seq_new.fend = xlast && ylast;
    end

    // --------------------------------------------------------------- sequencer
    always_comb
    begin
        seq_next = seq_reg;
        if (advance && seq_reg.a_v && seq_reg.b_v)
        begin
            seq_next.a_v = 1'b0;
        end
        else if (in_fire)
        begin
            seq_next = seq_new;
        end
        else if (advance)
        begin
            seq_next.a_v = 1'b0;
            seq_next.b_v = 1'b0;
        end
    end

    always_comb
    begin
        iss.v    = seq_reg.a_v || seq_reg.b_v;
        iss.h    = seq_reg.a_v ? seq_reg.ha : seq_reg.hb;
        iss.xh   = seq_reg.a_v ? seq_reg.xa : seq_reg.xb;
        iss.y    = seq_reg.y;
        iss.yz   = seq_reg.yz;
        iss.e1   = seq_reg.e1;
        iss.e2   = seq_reg.e2;
        iss.last = !(seq_reg.a_v && seq_reg.b_v);
        iss.fend = seq_reg.fend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            op_reg  <= '0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (advance)
            begin
                op_reg  <= iss;
                // same column written while being read: take the write data
                fwd_reg <= wr_en && iss.v && (iss.xh == op_reg.xh);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_data_reg <= wr_pair;
        end
    end

    // ------------------------------------------------------------ line buffer
    assign rd_pair   = fwd_reg ? fwd_data_reg : mem_rd;
    assign older_pix = rd_pair[PAIR_W-1:PIX_W];
    assign newer_pix = rd_pair[PIX_W-1:0];
    assign wr_en     = advance && op_reg.v;
    // top row fills both rows so that it is replicated upwards
    assign wr_pair   = op_reg.yz ? {op_reg.h, op_reg.h} : {newer_pix, op_reg.h};

    sbb_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (advance),
        .rd_addr (iss.xh),
        .rd_data (mem_rd),
        .wr_en   (wr_en),
        .wr_addr (op_reg.xh),
        .wr_data (wr_pair)
    );

    // ------------------------------------------------------------------ lanes
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            sbb_lane u_lane (
                .left   (left_pix[c*CH_W +: CH_W]),
                .centre (prev_reg[c*CH_W +: CH_W]),
                .right  (cur_pix[c*CH_W +: CH_W]),
                .older  (older_pix[c*CH_W +: CH_W]),
                .newer  (newer_pix[c*CH_W +: CH_W]),
                .h      (op_reg.h[c*CH_W +: CH_W]),
                .h_a    (ha_pix[c*CH_W +: CH_W]),
                .h_b    (hb_pix[c*CH_W +: CH_W]),
                .v_a    (va_pix[c*CH_W +: CH_W]),
                .v_b    (vb_pix[c*CH_W +: CH_W])
            );
        end
        else
        begin : g_off
            assign ha_pix[c*CH_W +: CH_W] = '0;
            assign hb_pix[c*CH_W +: CH_W] = '0;
            assign va_pix[c*CH_W +: CH_W] = '0;
            assign vb_pix[c*CH_W +: CH_W] = '0;
        end
    end

    // ------------------------------------------------------------------ output
    sbb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op_reg),
        .va       (va_pix),
        .vb       (vb_pix),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/tb_separable_binomial_blur_3x3.sv =====
// Self-checking stream testbench for the separable 3x3 binomial blur.
`timescale 1ns / 1ps

module tb_separable_binomial_blur_3x3;
    import sbb_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_PIXELS = 180;
    localparam int MAX_PRINTS = 60;
    localparam longint TIMEOUT_NS = 64'd2_000_000;

    typedef logic [PIX_W-1:0] pix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // red_in, green_in, blue_in
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // red, green, blue, out_col, out_row, pad
    logic                   m_tlast;         // run_end
    logic [0:0]             m_tuser;         // frame_end
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;

    separable_binomial_blur_3x3 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Blur model state
    pix_t             hb_line_a [MAX_WIDTH];   // older horizontal row
    pix_t             hb_line_b [MAX_WIDTH];   // newer horizontal row
    pix_t             last_px = '0;
    pix_t             last2_px = '0;
    int unsigned      px_col = 0;
    int unsigned      px_row = 0;
    logic [CFG_W-1:0] reg_w = WIDTH_RST;
    logic [CFG_W-1:0] reg_h = HEIGHT_RST;
    logic             reg_border = BORDER_RST;

    res_t        blurred_q [$];
    pix_t        raw_px_q [$];
    int unsigned px_queued = 0;
    int unsigned px_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;

    function automatic int unsigned eff_size(logic [CFG_W-1:0] raw, int unsigned hi);
        int unsigned v;
        v = 32'(raw);
        if (v < 32'(SIZE_MIN))
            return 32'(SIZE_MIN);
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic pix_t blur121(pix_t a, pix_t b, pix_t c);
        pix_t            r;
        logic [CH_W+1:0] sum;
        int              k;
        r = '0;
        for (k = 0; k < NUM_CH; k++)
        begin
            sum = (CH_W+2)'(a[k*CH_W +: CH_W]) + ((CH_W+2)'(b[k*CH_W +: CH_W]) << 1)
                + (CH_W+2)'(c[k*CH_W +: CH_W]);
            r[k*CH_W +: CH_W] = sum[CH_W+1:2];
        end
        return r;
    endfunction

    function automatic void push_blurred(pix_t p, int unsigned c, int unsigned r);
        res_t item;
        item.pix       = p;
        item.col       = COORD_W'(c);
        item.row       = COORD_W'(r);
        item.run_end   = 1'b0;
        item.frame_end = 1'b0;
        blurred_q.push_back(item);
    endfunction

    // Vertical pass for one new horizontal value
    function automatic void update_column(int unsigned xh, pix_t hval, int unsigned y,
                                          bit ylast);
        pix_t older;
        pix_t newer;
        if (xh >= MAX_WIDTH)
            return;
        older = hb_line_a[xh];
        newer = hb_line_b[xh];
        if (y == 0)
        begin
            // replicate the top row into both lines
            hb_line_a[xh] = hval;
            hb_line_b[xh] = hval;
            return;
        end
        if (reg_border || y >= 2)
            push_blurred(blur121(older, newer, hval), xh, y - 1);
        if (reg_border && ylast)
            push_blurred(blur121(newer, hval, hval), xh, y);
        hb_line_a[xh] = newer;
        hb_line_b[xh] = hval;
    endfunction

    function automatic void advance_blur(pix_t cur);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned n0;
        bit          xlast;
        bit          ylast;
        pix_t        left;
        w = eff_size(reg_w, MAX_WIDTH);
        h = eff_size(reg_h, MAX_HEIGHT);
        x = px_col;
        y = px_row;
        xlast = x >= w - 1;
        ylast = y >= h - 1;
        n0 = blurred_q.size();
        if (reg_border)
        begin
            if (x >= 1)
            begin
                left = (x == 1) ? last_px : last2_px;
                update_column(x - 1, blur121(left, last_px, cur), y, ylast);
            end
            if (xlast)
                update_column(x, blur121(last_px, cur, cur), y, ylast);
        end
        else if (x >= 2)
        begin
            update_column(x - 1, blur121(last2_px, last_px, cur), y, ylast);
        end
        last2_px = last_px;
        last_px = cur;
        if (xlast)
        begin
            px_col = 0;
            px_row = ylast ? 0 : y + 1;
        end
        else
        begin
            px_col = x + 1;
        end
        if (blurred_q.size() > n0)
        begin
            blurred_q[blurred_q.size()-1].run_end = 1'b1;
            blurred_q[blurred_q.size()-1].frame_end = xlast && ylast;
        end
    endfunction

    // Pixels left until the current frame wraps, from the model counters
    function automatic int unsigned frame_remaining();
        int unsigned w;
        int unsigned h;
        int unsigned cols_left;
        w = eff_size(reg_w, MAX_WIDTH);
        h = eff_size(reg_h, MAX_HEIGHT);
        cols_left = (px_col >= w - 1) ? 1 : w - px_col;
        return (px_row >= h - 1) ? cols_left : cols_left + (h - 1 - px_row) * w;
    endfunction

    function automatic pix_t rand_pixel();
        pix_t p;
        int   k;
        p = '0;
        for (k = 0; k < NUM_CH; k++)
        begin
            case ($urandom_range(0, 7))
                0:       p[k*CH_W +: CH_W] = '0;
                1:       p[k*CH_W +: CH_W] = '1;
                default: p[k*CH_W +: CH_W] = CH_W'($urandom);
            endcase
        end
        return p;
    endfunction

    function automatic void queue_pixel(pix_t p);
        raw_px_q.push_back(p);
        px_queued++;
    endfunction

    task automatic queue_random(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            queue_pixel(rand_pixel());
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // Hold until every queued pixel is taken and every result is back
    task automatic wait_drained();
        while (px_accepted != px_queued || blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_w = value;
            CFG_HEIGHT: reg_h = value;
            CFG_BORDER: reg_border = value[0];
            default:    ;
        endcase
        reg_writes++;
    endtask

    // Input driver: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_blur(s_tdata[PIX_W-1:0]);
                px_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (raw_px_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'(raw_px_q.pop_front());
                    if (burst_left != 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output sink: changing stall patterns plus one long hold-off
    int unsigned sink_taken = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_done = 1'b0;
    int unsigned style_left = 0;
    int unsigned sink_style = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sink_taken++;
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            // start the hold-off while pixels are still waiting to go in
            else if (!holdoff_done && sink_taken >= 40 && raw_px_q.size() >= 8)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    sink_style = $urandom_range(0, 3);
                    style_left = $urandom_range(10, 60);
                end
                style_left--;
                case (sink_style)
                    2:       m_tready <= ($urandom_range(0, 1) == 0);
                    3:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Result checker
    res_t got_px;
    res_t want_px;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_px.pix       = m_tdata[PIX_W-1:0];
            got_px.col       = m_tdata[PIX_W +: COORD_W];
            got_px.row       = m_tdata[PIX_W+COORD_W +: COORD_W];
            got_px.run_end   = m_tlast;
            got_px.frame_end = m_tuser[0];
            if (blurred_q.size() == 0)
            begin
                report_mismatch("unexpected transfer, col", 32'(got_px.col), 32'd0);
            end
            else
            begin
                want_px = blurred_q.pop_front();
                if (got_px.pix[0 +: CH_W] != want_px.pix[0 +: CH_W])
                    report_mismatch("red", 32'(got_px.pix[0 +: CH_W]),
                                    32'(want_px.pix[0 +: CH_W]));
                if (got_px.pix[CH_W +: CH_W] != want_px.pix[CH_W +: CH_W])
                    report_mismatch("green", 32'(got_px.pix[CH_W +: CH_W]),
                                    32'(want_px.pix[CH_W +: CH_W]));
                if (got_px.pix[2*CH_W +: CH_W] != want_px.pix[2*CH_W +: CH_W])
                    report_mismatch("blue", 32'(got_px.pix[2*CH_W +: CH_W]),
                                    32'(want_px.pix[2*CH_W +: CH_W]));
                if (got_px.col != want_px.col)
                    report_mismatch("out_col", 32'(got_px.col), 32'(want_px.col));
                if (got_px.row != want_px.row)
                    report_mismatch("out_row", 32'(got_px.row), 32'(want_px.row));
                if (got_px.run_end != want_px.run_end)
                    report_mismatch("run_end", 32'(got_px.run_end), 32'(want_px.run_end));
                if (got_px.frame_end != want_px.frame_end)
                    report_mismatch("frame_end", 32'(got_px.frame_end),
                                    32'(want_px.frame_end));
            end
            if (got_px.frame_end)
                frames_seen++;
            results_seen++;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL separable_binomial_blur_3x3");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        int unsigned random_px;
        int unsigned total;
        int unsigned split;
        int unsigned guard;
        int unsigned cur_w;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Border mode, undersized registers clamp up to 3x3, channel extremes
        write_reg(CFG_WIDTH, 12'd1);
        write_reg(CFG_HEIGHT, 12'd2);
        write_reg(CFG_BORDER, 12'd1);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h00FF00);
        queue_pixel(24'hFF00FF);
        queue_pixel(24'h123456);
        queue_pixel(24'h0000FF);
        queue_pixel(24'hFFFFFF);
        wait_drained();

        // Interior only: one result per 3x3 frame
        write_reg(CFG_BORDER, 12'd0);
        write_reg(CFG_WIDTH, 12'd3);
        write_reg(CFG_HEIGHT, 12'd3);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        wait_drained();

        // Oversized registers clamp to the maximum, then shrink mid-row
        write_reg(CFG_BORDER, 12'd1);
        write_reg(CFG_WIDTH, 12'hFFF);
        write_reg(CFG_HEIGHT, 12'hFFF);
        queue_random(4);
        wait_drained();
        write_reg(CFG_WIDTH, 12'd3);
        write_reg(CFG_HEIGHT, 12'd2);
        queue_random(frame_remaining());
        wait_drained();

        // Random frames, some resized or switched to interior mid-frame
        random_px = 0;
        while (random_px < RANDOM_PIXELS)
        begin
            write_reg(CFG_WIDTH, ($urandom_range(0, 9) == 0) ?
                      CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 12)));
            write_reg(CFG_HEIGHT, ($urandom_range(0, 9) == 0) ?
                      CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 7)));
            write_reg(CFG_BORDER, CFG_W'($urandom_range(0, 1)));
            total = frame_remaining();
            if ($urandom_range(0, 3) == 0)
            begin
                split = $urandom_range(1, total - 1);
                queue_random(split);
                random_px += split;
                wait_drained();
                cur_w = eff_size(reg_w, MAX_WIDTH);
                // only shrink the width so that no unwritten line entry is read
                case ($urandom_range(0, 2))
                    0:       write_reg(CFG_HEIGHT, CFG_W'($urandom_range(0, 8)));
                    1:       write_reg(CFG_WIDTH, CFG_W'($urandom_range(0, cur_w)));
                    default:
                    begin
                        if (reg_border)
                            write_reg(CFG_BORDER, 12'd0);
                        else
                            write_reg(CFG_HEIGHT, CFG_W'($urandom_range(0, 8)));
                    end
                endcase
            end
            total = frame_remaining();
            queue_random(total);
            random_px += total;
            wait_drained();
        end

        for (guard = 0; guard < 50000 && (px_accepted != px_queued || blurred_q.size() != 0);
             guard++)
            @(posedge clk);
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (px_accepted != px_queued)
            report_mismatch("pixels never taken", px_queued - px_accepted, 32'd0);
        if (blurred_q.size() != 0)
            report_mismatch("results never delivered", 32'(blurred_q.size()), 32'd0);

        $display("run covered %0d pixels, %0d blurred results over %0d frames, %0d reg writes",
                 px_accepted, results_seen, frames_seen, reg_writes);
        $display("both border modes, clamped sizes, mid-frame resizes and a long output stall");
        if (mismatches == 0)
            $display("PASS separable_binomial_blur_3x3");
        else
            $display("FAIL separable_binomial_blur_3x3");
        $finish;
    end

endmodule
